>>> hdl/srec_pkg.sv
// Shared types, constants and decode helpers for the S-record line parser.
// No dependencies; every other file in hdl/ imports this package.
package srec_pkg;

  // Default for the longest line that is still parsed.
  localparam int unsigned MAX_LINE_CHARS = 514;

  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_F     = 8'h46;
  localparam logic [7:0] SUM_TARGET = 8'hFF;

  // Line positions of the count byte and of the first address digit.
  localparam int unsigned COUNT_POS      = 2;
  localparam int unsigned FIRST_ADDR_POS = 4;
  // Fixed characters in a minimal line: S, type, count pair, checksum pair.
  localparam int unsigned MIN_LINE_FIXED = 6;

  typedef enum logic [1:0] {
    ST_START    = 2'd0,
    ST_PROGRESS = 2'd1,
    ST_DONE     = 2'd2,
    ST_ERROR    = 2'd3
  } status_e;

  // One input beat.
  typedef struct packed {
    logic [7:0] character;
    logic       end_of_line;
  } char_beat_t;

  // One result beat.
  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  record_type;
    logic [7:0]  data_length;
    status_e     status;
    logic        is_summary;
  } result_t;

  // Hex digit value; anything outside 0-9 and A-F decodes as zero.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      t = c - CHAR_ZERO;
    end else if (c >= CHAR_A && c <= CHAR_F) begin
      t = c - CHAR_A + 8'd10;
    end
    return t[3:0];
  endfunction

  // Address length in bytes for each record type; zero marks a bad type.
  function automatic logic [2:0] addr_len(input logic [3:0] t);
    logic [2:0] n;
    case (t)
      4'd0, 4'd1, 4'd5, 4'd9: n = 3'd2;
      4'd2, 4'd6, 4'd8:       n = 3'd3;
      4'd3, 4'd7:             n = 3'd4;
      default:                n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

>>> hdl/srec_if.sv
// Valid/ready channel interfaces for the S-record parser.
// Depends on srec_pkg for the beat types.
interface srec_char_if;
  import srec_pkg::*;
  logic       valid;
  logic       ready;
  char_beat_t beat;

  modport source (output valid, output beat, input ready);
  modport sink   (input valid, input beat, output ready);
endinterface

interface srec_result_if;
  import srec_pkg::*;
  logic    valid;
  logic    ready;
  result_t beat;

  modport source (output valid, output beat, input ready);
  modport sink   (input valid, input beat, output ready);
endinterface

>>> hdl/srec_in_reg.sv
// Input register of the S-record parser: holds one character beat.
// Depends on srec_pkg and srec_char_if.
module srec_in_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  srec_char_if.sink             chars_i,
  input  logic                  advance_i,
  output logic                  valid_o,
  output srec_pkg::char_beat_t  beat_o
);
  import srec_pkg::*;

  logic       valid_q;
  char_beat_t beat_q;

  // A new beat may enter when the register is empty or is drained this cycle.
  assign chars_i.ready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (chars_i.ready) begin
      valid_q <= chars_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chars_i.ready && chars_i.valid) begin
      beat_q <= chars_i.beat;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;
endmodule

>>> hdl/srec_core.sv
// Line state and per-character decode of the S-record parser.
// Depends on srec_pkg for the decode helpers and result type.
module srec_core #(
  parameter int unsigned MaxLineChars = srec_pkg::MAX_LINE_CHARS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  srec_pkg::char_beat_t  beat_i,
  output logic                  emit_o,
  output srec_pkg::result_t     result_o
);
  import srec_pkg::*;

  localparam int unsigned PosW = $clog2(MaxLineChars + 1);
  localparam int unsigned CmpW = (PosW > 8) ? PosW : 8;
  localparam logic [PosW-1:0] PosMax = PosW'(MaxLineChars);

  logic [PosW-1:0] pos_q, pos_d;
  logic [3:0]      type_q, type_d;
  logic [2:0]      ab_q, ab_d;
  logic [7:0]      count_q, count_d;
  logic [7:0]      sum_q, sum_d;
  logic [31:0]     addr_q, addr_d;
  logic [3:0]      hi_q, hi_d;
  logic            err_q, err_d;

  logic [3:0]      nib;
  logic [7:0]      byte_v;
  logic [PosW-1:0] k;
  logic [PosW-1:0] addr_end;
  logic [PosW-1:0] min_len;
  logic [7:0]      dlen;
  logic            bad;
  status_e         st;

  assign nib    = nibble_of(beat_i.character);
  assign byte_v = {hi_q, nib};
  assign k      = (pos_q - PosW'(3)) >> 1;
  assign addr_end = PosW'(FIRST_ADDR_POS) + PosW'({ab_q, 1'b0});

  // Next line state for the character in the input register.
  always_comb begin
    pos_d   = pos_q;
    type_d  = type_q;
    ab_d    = ab_q;
    count_d = count_q;
    sum_d   = sum_q;
    addr_d  = addr_q;
    hi_d    = hi_q;
    err_d   = err_q;
    emit_o  = 1'b0;
    if (pos_q < PosMax) begin
      if (pos_q == '0) begin
        if (beat_i.character != CHAR_S) begin
          err_d = 1'b1;
        end
      end else if (pos_q == PosW'(1)) begin
        if (beat_i.character < CHAR_ZERO || beat_i.character > CHAR_NINE) begin
          err_d = 1'b1;
        end
        type_d = nib;
        ab_d   = addr_len(nib);
      end else begin
        // Address digits shift in; an S0 address must be all zero characters.
        if (pos_q >= PosW'(FIRST_ADDR_POS) && pos_q < addr_end) begin
          addr_d = {addr_q[27:0], nib};
          if (type_q == 4'd0 && beat_i.character != CHAR_ZERO) begin
            err_d = 1'b1;
          end
        end
        if (!pos_q[0]) begin
          hi_d = nib;
        end else begin
          sum_d = sum_q + byte_v;
          if (pos_q == PosW'(COUNT_POS + 1)) begin
            count_d = byte_v;
          end else if (!beat_i.end_of_line && type_q <= 4'd3 && ab_q != 3'd0 &&
                       CmpW'(k) > CmpW'(ab_q) && CmpW'(k) < CmpW'(count_q)) begin
            emit_o = 1'b1;
          end
        end
      end
      pos_d = pos_q + PosW'(1);
    end else begin
      err_d = 1'b1;
    end
    if (beat_i.end_of_line) begin
      emit_o = 1'b1;
    end
  end

  // Data length from the updated state.
  always_comb begin
    dlen = 8'd0;
    if (type_d <= 4'd3 && {1'b0, count_d} >= {6'd0, ab_d} + 9'd1) begin
      dlen = count_d - {5'd0, ab_d} - 8'd1;
    end
  end

  // Line-end checks and status.
  assign min_len = PosW'(MIN_LINE_FIXED) + PosW'({ab_d, 1'b0});
  assign bad = err_d || pos_d[0] || (pos_d < min_len) || (ab_d == 3'd0) ||
               (sum_d != SUM_TARGET);

  always_comb begin
    if (bad) begin
      st = ST_ERROR;
    end else if (type_d == 4'd0) begin
      st = ST_START;
    end else if (type_d >= 4'd7) begin
      st = ST_DONE;
    end else begin
      st = ST_PROGRESS;
    end
  end

  // Result beat: the summary at line end, otherwise a data byte.
  always_comb begin
    result_o.record_type = type_d;
    result_o.data_length = dlen;
    if (beat_i.end_of_line) begin
      result_o.value      = addr_d;
      result_o.status     = st;
      result_o.is_summary = 1'b1;
    end else begin
      result_o.value      = {24'd0, byte_v};
      result_o.status     = ST_START;
      result_o.is_summary = 1'b0;
    end
  end

  // State registers; a line end returns everything to the reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      type_q  <= '0;
      ab_q    <= '0;
      count_q <= '0;
      sum_q   <= '0;
      addr_q  <= '0;
      hi_q    <= '0;
      err_q   <= 1'b0;
    end else if (advance_i) begin
      if (beat_i.end_of_line) begin
        pos_q   <= '0;
        type_q  <= '0;
        ab_q    <= '0;
        count_q <= '0;
        sum_q   <= '0;
        addr_q  <= '0;
        hi_q    <= '0;
        err_q   <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        type_q  <= type_d;
        ab_q    <= ab_d;
        count_q <= count_d;
        sum_q   <= sum_d;
        addr_q  <= addr_d;
        hi_q    <= hi_d;
        err_q   <= err_d;
      end
    end
  end
endmodule

>>> hdl/srec_out_reg.sv
// Output register of the S-record parser: holds one result beat.
// Depends on srec_pkg and srec_result_if.
module srec_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  srec_pkg::result_t  result_i,
  output logic               can_load_o,
  srec_result_if.source      results_o
);
  import srec_pkg::*;

  logic    valid_q;
  result_t beat_q;

  // The register takes a new beat when empty or when its beat leaves now.
  assign can_load_o = !valid_q || results_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      beat_q <= result_i;
    end
  end

  assign results_o.valid = valid_q;
  assign results_o.beat  = beat_q;
endmodule

>>> hdl/srec_line_parser.sv
// Top level of the Motorola S-record line parser.
// Depends on srec_pkg, srec_if, srec_in_reg, srec_core and srec_out_reg.
//
// Usage:
//   chars_i takes one ASCII character of a record line per beat, with
//   end_of_line set on the second checksum digit; the newline is not sent.
//   results_o gives one beat per decoded data byte of an S0-S3 record and
//   one summary beat (is_summary set) per line, carrying the address, type,
//   data length and status.
// Timing:
//   One character per cycle is sustained while results_o takes its beats. A
//   character is registered on entry and decoded against the line state in
//   the next cycle; its result is then registered in the output register and
//   offered on results_o from there. The combinational decode-and-accumulate
//   path in srec_core sets this rate.
// Reset:
//   rst_ni clears both beat registers and the line state; the parser then
//   expects the 'S' of a new line. A line end clears the line state again.
// Stalls:
//   While results_o is stalled with a beat waiting, characters that yield no
//   result still pass; one that yields a result waits in the input register
//   and chars_i.ready drops until the output beat is taken.
module srec_line_parser #(
  parameter int unsigned MaxLineChars = srec_pkg::MAX_LINE_CHARS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  srec_char_if.sink      chars_i,
  srec_result_if.source  results_o
);
  import srec_pkg::*;

  logic       in_valid;
  char_beat_t in_beat;
  logic       emit;
  result_t    result;
  logic       can_load;
  logic       advance;

  // Retire the held character unless its result has nowhere to go.
  assign advance = in_valid && (!emit || can_load);

  srec_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .chars_i   (chars_i),
    .advance_i (advance),
    .valid_o   (in_valid),
    .beat_o    (in_beat)
  );

  srec_core #(
    .MaxLineChars (MaxLineChars)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .beat_i    (in_beat),
    .emit_o    (emit),
    .result_o  (result)
  );

  srec_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && emit),
    .result_i   (result),
    .can_load_o (can_load),
    .results_o  (results_o)
  );
endmodule
